// ===== design/assert_macros.svh =====
// Assertion macros shared by the distance field parser RTL.
// Each macro expects a clock named i_clk in scope; OCRDF_ASSERT also an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define OCRDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define OCRDF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/ocrdf_pkg.sv =====
// Types, constants and character-class helpers for the distance field parser.
// No dependencies; used by every module of the block.
`default_nettype none

package ocrdf_pkg;

    localparam int LINE_LEN = 256;
    localparam logic [7:0] POS_CAP = (LINE_LEN - 1 > 255) ? 8'd255 : 8'(LINE_LEN - 1);

    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] MAX_TENTHS = ACC_W'(1800);
    localparam logic [2:0] MAX_INT_DIGITS = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT,
        PH_SEP,
        PH_FRAC,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FIRST,
        ST_DIGITS,
        ST_FRAC,
        ST_CHAR,
        ST_RANGE,
        ST_AZIM
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_start;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [10:0] distance_tenths;
        logic [7:0]  azimuth_pos;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_DASH) || (c == CH_COLON) || (c == CH_APOS);
    endfunction

    // OCR confusions inside the field: 'i' reads as 1, 'S' as 5
    function automatic logic [7:0] fix_ocr(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_I) begin
            r = CH_ONE;
        end else if (c == CH_S) begin
            r = CH_FIVE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ocrdf_in_stage.sv =====
// Input register for one character transaction.
// Depends on ocrdf_pkg for the item type.
`default_nettype none

module ocrdf_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_char_code,
    input  wire logic            i_line_start,
    input  wire logic            i_take,
    output logic                 o_valid,
    output ocrdf_pkg::t_item     o_item
);

    logic             r_valid;
    ocrdf_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.char_code  <= i_char_code;
            r_item.line_start <= i_line_start;
        end
    end

endmodule

`default_nettype wire

// ===== design/ocrdf_parser.sv =====
// Parse state machine: one held character per cycle while i_go is high, accumulator and position counter.
// Depends on ocrdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ocrdf_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire ocrdf_pkg::t_item  i_item,
    output logic                   o_emit,
    output ocrdf_pkg::t_result     o_result
);

    localparam int W = ocrdf_pkg::ACC_W;

    ocrdf_pkg::t_phase r_phase, n_phase;
    logic [W-1:0]      r_accum, n_accum;
    logic [2:0]        r_count, n_count;
    logic [7:0]        r_pos, n_pos;

    logic [7:0]        raw, c;
    logic              start, dig_c, ws_c, sep_c, dig_raw, ws_raw, over;
    logic [W-1:0]      accum_x10;
    ocrdf_pkg::t_status status;

    // character classes and shared datapath
    always_comb begin
        raw       = i_item.char_code;
        start     = i_item.line_start;
        c         = ocrdf_pkg::fix_ocr(raw);
        dig_c     = ocrdf_pkg::is_digit(c);
        ws_c      = ocrdf_pkg::is_ws(c);
        sep_c     = ocrdf_pkg::is_sep(c);
        dig_raw   = ocrdf_pkg::is_digit(raw);
        ws_raw    = ocrdf_pkg::is_ws(raw);
        over      = r_accum > ocrdf_pkg::MAX_TENTHS;
        accum_x10 = (r_accum << 3) + (r_accum << 1) + {{(W-4){1'b0}}, c[3:0]};
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (start) begin
            n_phase = dig_raw ? ocrdf_pkg::PH_INT : ocrdf_pkg::PH_IDLE;
        end else begin
            unique case (r_phase)
                ocrdf_pkg::PH_INT: begin
                    if (dig_c) begin
                        n_phase = (r_count == ocrdf_pkg::MAX_INT_DIGITS) ?
                                  ocrdf_pkg::PH_IDLE : ocrdf_pkg::PH_INT;
                    end else if (sep_c) begin
                        n_phase = ocrdf_pkg::PH_SEP;
                    end else if (ws_c) begin
                        n_phase = over ? ocrdf_pkg::PH_IDLE : ocrdf_pkg::PH_SKIP;
                    end else begin
                        n_phase = ocrdf_pkg::PH_IDLE;
                    end
                end
                ocrdf_pkg::PH_SEP: begin
                    n_phase = dig_c ? ocrdf_pkg::PH_FRAC : ocrdf_pkg::PH_IDLE;
                end
                ocrdf_pkg::PH_FRAC: begin
                    n_phase = (ws_c && !over) ? ocrdf_pkg::PH_SKIP : ocrdf_pkg::PH_IDLE;
                end
                ocrdf_pkg::PH_SKIP: begin
                    n_phase = ws_raw ? ocrdf_pkg::PH_SKIP : ocrdf_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = ocrdf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // datapath updates and result
    always_comb begin
        o_emit  = 1'b0;
        status  = ocrdf_pkg::ST_OK;
        n_accum = r_accum;
        n_count = r_count;
        n_pos   = (r_pos < ocrdf_pkg::POS_CAP) ? r_pos + 8'd1 : r_pos;
        if (start) begin
            n_pos = '0;
            if (dig_raw) begin
                n_accum = {{(W-4){1'b0}}, raw[3:0]};
                n_count = 3'd1;
            end else begin
                n_accum = '0;
                n_count = '0;
                o_emit  = 1'b1;
                status  = ocrdf_pkg::ST_FIRST;
            end
        end else begin
            unique case (r_phase)
                ocrdf_pkg::PH_INT: begin
                    if (dig_c) begin
                        n_count = r_count + 3'd1;
                        if (r_count == ocrdf_pkg::MAX_INT_DIGITS) begin
                            o_emit = 1'b1;
                            status = ocrdf_pkg::ST_DIGITS;
                        end else begin
                            n_accum = accum_x10;
                        end
                    end else if (sep_c) begin
                        o_emit = 1'b0;
                    end else if (ws_c) begin
                        o_emit = over;
                        status = ocrdf_pkg::ST_RANGE;
                    end else begin
                        o_emit = 1'b1;
                        status = ocrdf_pkg::ST_CHAR;
                    end
                end
                ocrdf_pkg::PH_SEP: begin
                    if (dig_c) begin
                        n_accum = accum_x10;
                    end else begin
                        o_emit = 1'b1;
                        status = ocrdf_pkg::ST_FRAC;
                    end
                end
                ocrdf_pkg::PH_FRAC: begin
                    o_emit = !ws_c || over;
                    status = ws_c ? ocrdf_pkg::ST_RANGE : ocrdf_pkg::ST_FRAC;
                end
                ocrdf_pkg::PH_SKIP: begin
                    if (!ws_raw) begin
                        o_emit = 1'b1;
                        status = (dig_raw || raw == ocrdf_pkg::CH_S) ?
                                 ocrdf_pkg::ST_OK : ocrdf_pkg::ST_AZIM;
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
        o_result.status          = status;
        o_result.distance_tenths = (status == ocrdf_pkg::ST_OK) ? r_accum[10:0] : 11'd0;
        o_result.azimuth_pos     = (status == ocrdf_pkg::ST_OK) ? n_pos : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ocrdf_pkg::PH_IDLE;
            r_accum <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    `OCRDF_ASSERT(a_emit_ends_line, i_go && o_emit |=> r_phase == ocrdf_pkg::PH_IDLE, "phase not idle after result")
    `OCRDF_ASSERT(a_int_count, r_phase == ocrdf_pkg::PH_INT |-> r_count >= 3'd1 && r_count <= ocrdf_pkg::MAX_INT_DIGITS, "digit count out of range in integer part")
    `OCRDF_ASSERT(a_ok_in_range, o_emit && o_result.status == ocrdf_pkg::ST_OK |-> r_accum <= ocrdf_pkg::MAX_TENTHS, "ok result above range limit")
    `OCRDF_ASSERT(a_skip_in_range, r_phase == ocrdf_pkg::PH_SKIP |-> !over, "skip phase entered with value over limit")

endmodule

`default_nettype wire

// ===== design/ocrdf_out_stage.sv =====
// Result register holding one status/distance/azimuth transaction.
// Depends on ocrdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ocrdf_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire ocrdf_pkg::t_result i_result,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic [10:0]             o_distance_tenths,
    output logic [7:0]              o_azimuth_pos
);

    logic               r_valid;
    ocrdf_pkg::t_result r_result;

    assign o_space           = !r_valid || i_ready;
    assign o_valid           = r_valid;
    assign o_status          = r_result.status;
    assign o_distance_tenths = r_result.distance_tenths;
    assign o_azimuth_pos     = r_result.azimuth_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    `OCRDF_ASSERT(a_no_overwrite, i_load |-> !r_valid || i_ready, "result overwritten before taken")
    `OCRDF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_valid, "result register not empty after reset")
    `OCRDF_ASSERT(a_status_code, r_valid |-> r_result.status <= ocrdf_pkg::ST_AZIM, "undefined status code held")

endmodule

`default_nettype wire

// ===== design/ocr_distance_field_parser_unit.sv =====
// Distance field parser: at most one result per line.
// Throughput one character per cycle while no result waits in the result register.
// An input register feeds the parse state machine, whose combinational update
// (one multiply by ten) writes the result register.
// Reset: synchronous active-low i_rst_n; parser idles until the next line start.
`default_nettype none

module ocr_distance_field_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_line_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [10:0]      o_distance_tenths,
    output logic [7:0]       o_azimuth_pos
);

    logic               held_valid, out_space, go, emit;
    ocrdf_pkg::t_item   held_item;
    ocrdf_pkg::t_result result;

    assign go = held_valid && out_space;

    ocrdf_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_char_code  (i_char_code),
        .i_line_start (i_line_start),
        .i_take       (go),
        .o_valid      (held_valid),
        .o_item       (held_item)
    );

    ocrdf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (result)
    );

    ocrdf_out_stage u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (go && emit),
        .i_result          (result),
        .o_space           (out_space),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_status          (o_status),
        .o_distance_tenths (o_distance_tenths),
        .o_azimuth_pos     (o_azimuth_pos)
    );

endmodule

`default_nettype wire
